@@ hw/rtl/sbwps_pkg.sv @@
// Shared constants and types for the sparse basis weighted point sum block.
`timescale 1ns / 1ps

package sbwps_pkg;

	// Control point store
	localparam int CTRL_POINTS = 4096;
	localparam int ADDR_W      = $clog2(CTRL_POINTS);

	// Field widths
	localparam int IDX_W   = 12;
	localparam int COORD_W = 32;
	localparam int WEIGHT_W = 16;
	localparam int PROD_W  = COORD_W + WEIGHT_W + 1;
	localparam int ACC_W   = 56;
	localparam int POINT_W = 3 * COORD_W;

	// Input tdata layout, lowest bit up
	localparam int IDX_LSB    = 0;
	localparam int X_LSB      = IDX_LSB + IDX_W;
	localparam int Y_LSB      = X_LSB + COORD_W;
	localparam int Z_LSB      = Y_LSB + COORD_W;
	localparam int WEIGHT_LSB = Z_LSB + COORD_W;
	localparam int IN_DATA_W  = ((WEIGHT_LSB + WEIGHT_W + 7) / 8) * 8;

	// Output queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	// Opcodes
	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_TERM = 2'd1,
		OP_EMIT = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	// One finished result
	typedef struct packed {
		logic                 sat;
		logic [COORD_W-1:0]   z;
		logic [COORD_W-1:0]   y;
		logic [COORD_W-1:0]   x;
	} result_t;

endpackage

@@ hw/rtl/sparse_basis_weighted_point_sum.sv @@
// Top level: control point store, weighted accumulation and result queue.
`timescale 1ns / 1ps

// Channel  Fields                                                    Accepted when
// s_*      tuser=opcode, tdata=index/x/y/z/weight, tlast=last_term   s_tvalid && s_tready
// m_*      tdata=point x/y/z, tuser=saturated                        m_tvalid && m_tready
//
// One item per cycle while s_tready is high. A term reads its control point
// from the single-port store at acceptance; the point is weighted in stage 2,
// added into the accumulators in stage 3, and a closing item's result is then
// written from emit_val_s3 into the 8-entry output queue. Reset clears the
// accumulators, the accumulate and emit flags and the queue; the store is left as is.
// s_tready drops only when the queue could not hold every result in flight.

module sparse_basis_weighted_point_sum (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// point_index[11:0], coord_x[43:12], coord_y[75:44], coord_z[107:76],
	// weight[123:108], zero[127:124]
	input  logic [sbwps_pkg::IN_DATA_W-1:0]     s_tdata,
	// opcode[1:0]
	input  logic [1:0]                          s_tuser,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// point_x[31:0], point_y[63:32], point_z[95:64]
	output logic [sbwps_pkg::POINT_W-1:0]       m_tdata,
	// saturated[0]
	output logic [0:0]                          m_tuser
);

	localparam int CW = sbwps_pkg::COORD_W;
	localparam int PW = sbwps_pkg::PROD_W;
	localparam int AW = sbwps_pkg::ACC_W;

	// Input field unpacking
	sbwps_pkg::op_t                       in_op;
	logic [sbwps_pkg::IDX_W-1:0]          in_idx;
	logic [sbwps_pkg::WEIGHT_W-1:0]       in_weight;
	logic [sbwps_pkg::POINT_W-1:0]        in_point;
	logic                                 in_range;
	logic                                 accept;

	assign in_op     = sbwps_pkg::op_t'(s_tuser);
	assign in_idx    = s_tdata[sbwps_pkg::IDX_LSB +: sbwps_pkg::IDX_W];
	assign in_weight = s_tdata[sbwps_pkg::WEIGHT_LSB +: sbwps_pkg::WEIGHT_W];
	assign in_point  = s_tdata[sbwps_pkg::X_LSB +: sbwps_pkg::POINT_W];
	assign in_range  = (32'(in_idx) < sbwps_pkg::CTRL_POINTS);
	assign accept    = s_tvalid && s_tready;

	// Control point store: write on load, read on term, one access per item
	logic [sbwps_pkg::POINT_W-1:0] store_mem [sbwps_pkg::CTRL_POINTS];
	logic [sbwps_pkg::POINT_W-1:0] rd_s1;

	always_ff @(posedge clk) begin
		if (accept && in_op == sbwps_pkg::OP_LOAD && in_range) begin
			store_mem[sbwps_pkg::ADDR_W'(in_idx)] <= in_point;
		end
		if (accept && in_op == sbwps_pkg::OP_TERM) begin
			rd_s1 <= store_mem[sbwps_pkg::ADDR_W'(in_idx)];
		end
	end

	// Stage 1: item flags beside the read data
	logic                           acc_s1, emit_s1, zero_s1;
	logic [sbwps_pkg::WEIGHT_W-1:0] weight_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1  <= 1'b0;
			emit_s1 <= 1'b0;
		end else begin
			acc_s1  <= accept && (in_op == sbwps_pkg::OP_TERM || in_op == sbwps_pkg::OP_EMIT);
			emit_s1 <= accept && ((in_op == sbwps_pkg::OP_TERM && s_tlast) ||
				in_op == sbwps_pkg::OP_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		weight_s1 <= in_weight;
		// an empty section adds nothing; an index beyond the store reads zero
		zero_s1   <= (in_op == sbwps_pkg::OP_EMIT) || !in_range;
	end

	// Stage 2: weight each coordinate
	logic                          acc_s2, emit_s2;
	logic signed [PW-1:0]          prod_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s2  <= 1'b0;
			emit_s2 <= 1'b0;
		end else begin
			acc_s2  <= acc_s1;
			emit_s2 <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (zero_s1) begin
				prod_s2[k] <= '0;
			end else begin
				prod_s2[k] <= PW'($signed(rd_s1[k*CW +: CW]) *
					$signed({1'b0, weight_s1}));
			end
		end
	end

	// Stage 3: saturating accumulate; on emit hand the sum on and clear
	logic signed [AW-1:0] acc_q [3];
	logic signed [AW-1:0] sum_sat [3];
	logic signed [AW-1:0] emit_val_s3 [3];
	logic                 emit_s3;

	always_comb begin
		logic signed [AW:0] sum;
		for (int k = 0; k < 3; k++) begin
			sum = {acc_q[k][AW-1], acc_q[k]} + (AW+1)'(prod_s2[k]);
			if (sum[AW] != sum[AW-1]) begin
				sum_sat[k] = sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
			end else begin
				sum_sat[k] = sum[AW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				acc_q[k] <= '0;
			end
			emit_s3 <= 1'b0;
		end else begin
			emit_s3 <= emit_s2;
			if (acc_s2) begin
				for (int k = 0; k < 3; k++) begin
					acc_q[k] <= emit_s2 ? '0 : sum_sat[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			emit_val_s3[k] <= sum_sat[k];
		end
	end

	// Round half up to Q16.16 and clip to 32 bits
	sbwps_pkg::result_t fin;

	always_comb begin
		logic signed [AW:0]    r;
		logic signed [AW-15:0] q;
		logic [CW-1:0]         c [3];
		logic                  clip;
		clip = 1'b0;
		for (int k = 0; k < 3; k++) begin
			r = {emit_val_s3[k][AW-1], emit_val_s3[k]} + (AW+1)'(16384);
			q = r[AW:15];
			if (q[AW-15:CW-1] != {(AW-CW-13){q[AW-15]}}) begin
				c[k] = q[AW-15] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
				clip = 1'b1;
			end else begin
				c[k] = q[CW-1:0];
			end
		end
		fin.x   = c[0];
		fin.y   = c[1];
		fin.z   = c[2];
		fin.sat = clip;
	end

	// Output queue
	sbwps_pkg::result_t               fifo_q [sbwps_pkg::FIFO_DEPTH];
	logic [sbwps_pkg::FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [sbwps_pkg::FIFO_CNT_W-1:0] count_q;
	logic                             push, pop;
	logic [sbwps_pkg::FIFO_CNT_W:0]   in_flight;

	assign push = emit_s3;
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Accept while every result in flight still has a queue slot
	assign in_flight = (sbwps_pkg::FIFO_CNT_W+1)'(count_q) +
		(sbwps_pkg::FIFO_CNT_W+1)'(emit_s1) +
		(sbwps_pkg::FIFO_CNT_W+1)'(emit_s2) +
		(sbwps_pkg::FIFO_CNT_W+1)'(emit_s3);
	assign s_tready  = (in_flight < (sbwps_pkg::FIFO_CNT_W+1)'(sbwps_pkg::FIFO_DEPTH));

	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {fifo_q[rd_ptr_q].z, fifo_q[rd_ptr_q].y, fifo_q[rd_ptr_q].x};
	assign m_tuser  = fifo_q[rd_ptr_q].sat;

	// Checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && count_q == sbwps_pkg::FIFO_CNT_W'(sbwps_pkg::FIFO_DEPTH)))
		else $error("result queue overflow");

	a_flight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_flight <= (sbwps_pkg::FIFO_CNT_W+1)'(sbwps_pkg::FIFO_DEPTH))
		else $error("more results in flight than queue slots");

	a_clear_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_s2 && emit_s2) |=> (acc_q[0] == '0 && acc_q[1] == '0 && acc_q[2] == '0))
		else $error("accumulators not cleared after emit");

	a_emit_is_acc: assert property (@(posedge clk) disable iff (!arst_n)
		emit_s1 |-> acc_s1)
		else $error("emit without accumulate step");

endmodule

@@ sim/tb_sparse_basis_weighted_point_sum.sv @@
// Self-checking testbench that predicts and compares every evaluated spline point.
`timescale 1ns / 1ps

module tb_sparse_basis_weighted_point_sum;

	localparam int     CW         = sbwps_pkg::COORD_W;
	localparam longint ACC_HI     = (longint'(1) <<< (sbwps_pkg::ACC_W - 1)) - 1;
	localparam longint ACC_LO     = -(longint'(1) <<< (sbwps_pkg::ACC_W - 1));
	localparam longint COORD_HI   = (longint'(1) <<< (CW - 1)) - 1;
	localparam longint COORD_LO   = -(longint'(1) <<< (CW - 1));
	localparam longint ROUND_HALF = 16384;
	localparam int     FRAC_SHIFT = 15;
	localparam int     WEIGHT_ONE = 32768;
	localparam int     MAX_GAP    = 8;
	localparam int     SETTLE_CYC = 20;
	localparam int     LIMIT_NS   = 5_000_000;
	localparam int     NPTS       = sbwps_pkg::CTRL_POINTS;

	typedef struct {
		sbwps_pkg::op_t                 op;
		logic [sbwps_pkg::IDX_W-1:0]    idx;
		logic [CW-1:0]                  x;
		logic [CW-1:0]                  y;
		logic [CW-1:0]                  z;
		logic [sbwps_pkg::WEIGHT_W-1:0] w;
		logic                           last;
	} item_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	// point_index[11:0], coord_x[43:12], coord_y[75:44], coord_z[107:76],
	// weight[123:108], zero[127:124]
	logic [sbwps_pkg::IN_DATA_W-1:0] s_tdata;
	// opcode[1:0]
	logic [1:0]                      s_tuser;
	logic                            s_tlast;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	// point_x[31:0], point_y[63:32], point_z[95:64]
	logic [sbwps_pkg::POINT_W-1:0]   m_tdata;
	// saturated[0]
	logic [0:0]                      m_tuser;

	// Predictor state: control point store and coordinate sums
	logic signed [CW-1:0]   cp_store [NPTS][3];
	bit                     loaded [NPTS];
	int                     loaded_slots[$];
	longint                 coord_acc [3];
	sbwps_pkg::result_t     pending_points[$];

	int fail_count     = 0;
	int items_sent     = 0;
	int points_checked = 0;
	int clipped_points = 0;
	int src_idle_pct   = 0;
	int snk_stall_pct  = 0;

	sparse_basis_weighted_point_sum dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// Stall the result side at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// Add with clamping to the accumulator range
	function automatic longint acc_sat_add(input longint a, input longint p);
		longint s;
		s = a + p;
		if (s > ACC_HI)
			return ACC_HI;
		if (s < ACC_LO)
			return ACC_LO;
		return s;
	endfunction

	// Round Q.31 half up to Q16.16 and clip to 32 bits
	function automatic logic [CW-1:0] round_clip(input longint acc, inout bit clipped);
		longint q;
		q = (acc + ROUND_HALF) >>> FRAC_SHIFT;
		if (q > COORD_HI) begin
			q = COORD_HI;
			clipped = 1'b1;
		end else if (q < COORD_LO) begin
			q = COORD_LO;
			clipped = 1'b1;
		end
		return q[CW-1:0];
	endfunction

	// Close the section: queue the point and clear the sums
	task automatic emit_point();
		sbwps_pkg::result_t pt;
		bit                 clipped;
		clipped = 1'b0;
		pt.x = round_clip(coord_acc[0], clipped);
		pt.y = round_clip(coord_acc[1], clipped);
		pt.z = round_clip(coord_acc[2], clipped);
		pt.sat = clipped;
		pending_points.push_back(pt);
		for (int k = 0; k < 3; k++)
			coord_acc[k] = 0;
	endtask

	// Advance the predictor by one accepted item
	task automatic predict_point(input item_t it);
		longint prod;
		case (it.op)
			sbwps_pkg::OP_LOAD: begin
				cp_store[it.idx][0] = it.x;
				cp_store[it.idx][1] = it.y;
				cp_store[it.idx][2] = it.z;
				if (!loaded[it.idx]) begin
					loaded[it.idx] = 1'b1;
					loaded_slots.push_back(int'(it.idx));
				end
			end
			sbwps_pkg::OP_TERM: begin
				for (int k = 0; k < 3; k++) begin
					prod = longint'(cp_store[it.idx][k]) * longint'(it.w);
					coord_acc[k] = acc_sat_add(coord_acc[k], prod);
				end
				if (it.last)
					emit_point();
			end
			sbwps_pkg::OP_EMIT: emit_point();
			default: ;
		endcase
	endtask

	function automatic item_t make_item(input sbwps_pkg::op_t op, input int idx,
			input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
			input int w, input bit last);
		item_t it;
		it.op = op;
		it.idx = idx[sbwps_pkg::IDX_W-1:0];
		it.x = x;
		it.y = y;
		it.z = z;
		it.w = w[sbwps_pkg::WEIGHT_W-1:0];
		it.last = last;
		return it;
	endfunction

	// Present one item, wait for acceptance, then predict
	task automatic send_item(input item_t it);
		logic [sbwps_pkg::IN_DATA_W-1:0] data;
		int                              gap;
		data = '0;
		data[sbwps_pkg::IDX_LSB +: sbwps_pkg::IDX_W] = it.idx;
		data[sbwps_pkg::X_LSB +: CW] = it.x;
		data[sbwps_pkg::Y_LSB +: CW] = it.y;
		data[sbwps_pkg::Z_LSB +: CW] = it.z;
		data[sbwps_pkg::WEIGHT_LSB +: sbwps_pkg::WEIGHT_W] = it.w;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < src_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= it.op;
		s_tlast <= it.last;
		do @(posedge clk); while (!s_tready);
		predict_point(it);
		items_sent++;
	endtask

	// Hold the sender until every expected point has arrived
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_points.size() != 0);
	endtask

	task automatic check_field(input string name, input logic [CW-1:0] want,
			input logic [CW-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endtask

	// Compare each accepted point with the oldest prediction
	always @(posedge clk) begin : check_point
		sbwps_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_points.size() == 0) begin
				$error("unexpected point: x=%h y=%h z=%h saturated=%0d",
					m_tdata[0 +: CW], m_tdata[CW +: CW],
					m_tdata[2*CW +: CW], m_tuser);
				fail_count++;
			end else begin
				want = pending_points.pop_front();
				check_field("point_x", want.x, m_tdata[0 +: CW]);
				check_field("point_y", want.y, m_tdata[CW +: CW]);
				check_field("point_z", want.z, m_tdata[2*CW +: CW]);
				check_field("saturated", CW'(want.sat), CW'(m_tuser));
				points_checked++;
				if (want.sat)
					clipped_points++;
			end
		end
	end

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic int rand_weight();
		case ($urandom_range(9))
			0: return 0;
			1: return WEIGHT_ONE;
			2, 3: return $urandom_range(0, 65535);
			default: return $urandom_range(0, WEIGHT_ONE);
		endcase
	endfunction

	function automatic bit rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	// Pick a slot that already holds a point
	function automatic int rand_slot();
		return loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
	endfunction

	// Extremes, rounding edges, clipping and every opcode
	task automatic test_directed();
		send_item(make_item(sbwps_pkg::OP_EMIT, 0, 0, 0, 0, 0, 0));
		send_item(make_item(sbwps_pkg::OP_LOAD, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0));
		send_item(make_item(sbwps_pkg::OP_LOAD, 4095, 32'hFFFF_FFFF, 32'h0000_0001,
			32'h0001_0000, 0, 0));
		send_item(make_item(sbwps_pkg::OP_LOAD, 12'hAAA, 32'h1234_5678, 32'hEDCB_A988,
			32'h0000_8000, 65535, 1));
		send_item(make_item(sbwps_pkg::OP_LOAD, 12'h555, $urandom, $urandom, $urandom,
			32768, 1));
		// rounding half up on both signs
		send_item(make_item(sbwps_pkg::OP_TERM, 4095, 0, 0, 0, 16384, 1));
		send_item(make_item(sbwps_pkg::OP_TERM, 4095, 0, 0, 0, 16385, 1));
		send_item(make_item(sbwps_pkg::OP_TERM, 4095, 0, 0, 0, 16383, 1));
		// unit and zero weight
		send_item(make_item(sbwps_pkg::OP_TERM, 12'hAAA, 0, 0, 0, WEIGHT_ONE, 1));
		send_item(make_item(sbwps_pkg::OP_TERM, 12'hAAA, 0, 0, 0, 0, 1));
		// extreme coordinates: clip at nearly two, exact at one
		send_item(make_item(sbwps_pkg::OP_TERM, 0, 0, 0, 0, 65535, 1));
		send_item(make_item(sbwps_pkg::OP_TERM, 0, 0, 0, 0, WEIGHT_ONE, 1));
		// open section closed by an emit
		send_item(make_item(sbwps_pkg::OP_TERM, 12'h555, 0, 0, 0, 1000, 0));
		send_item(make_item(sbwps_pkg::OP_TERM, 12'hAAA, 0, 0, 0, 20000, 0));
		send_item(make_item(sbwps_pkg::OP_EMIT, 12'hFFF, $urandom, $urandom, $urandom,
			65535, 1));
		// unused opcode and load inside a section leave the sums alone
		send_item(make_item(sbwps_pkg::OP_TERM, 12'hAAA, 0, 0, 0, 40000, 0));
		send_item(make_item(sbwps_pkg::OP_NONE, 12'h555, $urandom, $urandom, $urandom,
			65535, 1));
		send_item(make_item(sbwps_pkg::OP_LOAD, 12'h123, 32'h0000_0003, 32'h0,
			32'hFFFF_FFFD, 65535, 1));
		send_item(make_item(sbwps_pkg::OP_TERM, 12'h123, 0, 0, 0, 12345, 1));
		send_item(make_item(sbwps_pkg::OP_EMIT, 0, 0, 0, 0, 0, 0));
	endtask

	// Drive the 56-bit sums into their positive and negative limits
	task automatic test_acc_overflow();
		send_item(make_item(sbwps_pkg::OP_LOAD, 12'h800, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h0000_0001, 0, 0));
		for (int t = 1; t <= 300; t++)
			send_item(make_item(sbwps_pkg::OP_TERM, 12'h800, $urandom, $urandom, $urandom,
				65535, t == 300));
	endtask

	// Mostly well-formed sections of random terms, with loads and stray items
	task automatic test_random(input int n);
		int stop;
		int len;
		int r;
		bit by_emit;
		stop = items_sent + n;
		while (items_sent < stop) begin
			r = $urandom_range(99);
			if (r < 15) begin
				repeat ($urandom_range(1, 4))
					send_item(make_item(sbwps_pkg::OP_LOAD, $urandom_range(0, NPTS - 1),
						rand_coord(), rand_coord(), rand_coord(),
						$urandom_range(0, 65535), rand_bit()));
			end else if (r < 88) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
				by_emit = ($urandom_range(4) == 0);
				for (int t = 1; t <= len; t++)
					send_item(make_item(sbwps_pkg::OP_TERM, rand_slot(), rand_coord(),
						rand_coord(), rand_coord(), rand_weight(), !by_emit && t == len));
				if (by_emit)
					send_item(make_item(sbwps_pkg::OP_EMIT, $urandom_range(0, NPTS - 1),
						$urandom, $urandom, $urandom, $urandom_range(0, 65535),
						rand_bit()));
			end else if (r < 94) begin
				send_item(make_item(sbwps_pkg::OP_NONE, $urandom_range(0, NPTS - 1),
					$urandom, $urandom, $urandom, $urandom_range(0, 65535), rand_bit()));
			end else begin
				send_item(make_item(sbwps_pkg::OP_EMIT, $urandom_range(0, NPTS - 1),
					$urandom, $urandom, $urandom, $urandom_range(0, 65535), rand_bit()));
			end
		end
	endtask

	// Bound the run
	initial begin
		#(LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

	initial begin
		for (int k = 0; k < 3; k++)
			coord_acc[k] = 0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= sbwps_pkg::OP_NONE;
		s_tlast <= 1'b0;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		src_idle_pct = 20;
		snk_stall_pct = 61;
		test_directed();
		test_acc_overflow();
		test_random(440);
		wait_drained();

		src_idle_pct = 61;
		snk_stall_pct = 20;
		test_random(440);
		wait_drained();

		src_idle_pct = 0;
		snk_stall_pct = 0;
		test_random(440);

		// Let the last points drain, then watch for strays
		s_tvalid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);

		$display("Sent %0d items across three idling phases; checked %0d points, %0d clipped.",
			items_sent, points_checked, clipped_points);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/sbwps_pkg.sv
hw/rtl/sparse_basis_weighted_point_sum.sv
sim/tb_sparse_basis_weighted_point_sum.sv
